FILE: hdl/mvtm_pkg.sv
// Shared constants, types and the sine table function for the tone mixer.
package mvtm_pkg;

   localparam int VoiceCount  = 16;
   localparam int VoiceBits   = (VoiceCount > 1) ? $clog2(VoiceCount) : 1;
   localparam int SineEntries = 1024;
   localparam int SineBits    = $clog2(SineEntries);
   localparam logic [4:0]  AllVoices   = 5'd16;
   localparam logic [12:0] MixGain     = 13'd6626;
   localparam logic [15:0] LfsrTaps    = 16'hB400;
   localparam logic [15:0] LfsrSeed    = 16'hACE1;
   localparam int          SampleLimit = 30000;

   localparam logic [2:0] WaveSquare   = 3'd0;
   localparam logic [2:0] WaveSine     = 3'd1;
   localparam logic [2:0] WaveTriangle = 3'd2;
   localparam logic [2:0] WaveSaw      = 3'd3;
   localparam logic [2:0] WaveNoise    = 3'd4;

   localparam logic ModeSet  = 1'b0;
   localparam logic ModeTick = 1'b1;

   typedef struct packed {
      logic        mode;
      logic [4:0]  voice_select;
      logic [31:0] phase_step;
      logic [2:0]  waveform;
      logic [7:0]  level;
   } cmd_type;

   // Integer odd polynomial of the quarter wave, in Q30; evaluated at
   // elaboration or as constant logic for one table address.
   function automatic logic [63:0] quarter_sine(input logic [63:0] t);
      logic [63:0] t2;
      logic [63:0] r;
      t2 = (t * t) >> 30;
      r = 64'd172272;
      r = 64'd5026995 - ((r * t2) >> 30);
      r = 64'd85569305 - ((r * t2) >> 30);
      r = 64'd693598668 - ((r * t2) >> 30);
      r = 64'd1686629713 - ((r * t2) >> 30);
      return (r * t) >> 30;
   endfunction

   function automatic logic signed [15:0] sine_entry(input logic [SineBits-1:0] i);
      logic [63:0] a;
      logic [1:0]  quad;
      logic [63:0] frac;
      logic [63:0] t;
      logic [63:0] s;
      a = (64'(i) << 32) >> SineBits;
      quad = a[31:30];
      frac = {34'd0, a[29:0]};
      t = quad[0] ? (64'd1073741824 - frac) : frac;
      s = (quarter_sine(t) + 64'd16384) >> 15;
      if (s > 64'd32767) s = 64'd32767;
      return quad[1] ? -16'(s) : 16'(s);
   endfunction

   typedef logic signed [15:0] sine_rom_type [SineEntries];

   function automatic sine_rom_type build_sine();
      sine_rom_type rom;
      for (int i = 0; i < SineEntries; i++) begin
         rom[i] = sine_entry(SineBits'(i));
      end
      return rom;
   endfunction

   localparam sine_rom_type SineRom = build_sine();

endpackage

FILE: hdl/mvtm_if.sv
// Valid/ready channel interfaces for the request and response streams.
interface mvtm_req_if (input logic clock);
   logic        valid;
   logic        ready;
   logic        mode;
   logic [4:0]  voice_select;
   logic [31:0] phase_step;
   logic [2:0]  waveform;
   logic signed [10:0] volume;
   modport source (output valid, mode, voice_select, phase_step, waveform, volume,
                   input ready);
   modport sink (input valid, mode, voice_select, phase_step, waveform, volume,
                 output ready);
endinterface

interface mvtm_rsp_if (input logic clock);
   logic               valid;
   logic               ready;
   logic signed [15:0] sample;
   modport source (output valid, sample, input ready);
   modport sink (input valid, sample, output ready);
endinterface

FILE: hdl/mvtm_front.sv
// Front end: accepts requests, clamps volume and pushes commands into a queue.
module mvtm_front (
   input  logic               clock,
   input  logic               reset,
   mvtm_req_if.sink           req,
   output mvtm_pkg::cmd_type  cmd_data,
   output logic               cmd_valid,
   input  logic               cmd_pop
);
   import mvtm_pkg::*;

   cmd_type     q_ff [2];
   logic        wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0]  cnt_ff, cnt_in;
   cmd_type     push_cmd;
   logic        push;
   logic [7:0]  level;

   always_comb begin
      if (req.volume < 0) level = 8'd0;
      else if (req.volume > 11'sd255) level = 8'd255;
      else level = req.volume[7:0];
      push_cmd = '{mode: req.mode, voice_select: req.voice_select,
                   phase_step: req.phase_step, waveform: req.waveform, level: level};
   end

   assign req.ready = (cnt_ff != 2'd2);
   assign push      = req.valid && req.ready;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd_data  = q_ff[rd_ff];

   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = cmd_pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ff] <= push_cmd;
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule

FILE: hdl/mvtm_back.sv
// Back end: voice state and a sequencer that visits one voice per cycle during a tick.
module mvtm_back (
   input  logic               clock,
   input  logic               reset,
   input  mvtm_pkg::cmd_type  cmd_data,
   input  logic               cmd_valid,
   output logic               cmd_pop,
   mvtm_rsp_if.source         rsp
);
   import mvtm_pkg::*;

   typedef enum logic [1:0] {S_INIT, S_IDLE, S_RUN, S_DRAIN} state_type;

   state_type            state_ff;
   logic [VoiceBits-1:0] idx_ff;
   logic                 last_ff;
   logic [31:0] phase_ff [VoiceCount];
   logic [31:0] step_ff  [VoiceCount];
   logic [2:0]  wave_ff  [VoiceCount];
   logic [7:0]  level_ff [VoiceCount];
   logic [15:0] lfsr_ff  [VoiceCount];
   logic [VoiceCount-1:0] active_ff;

   // Pipeline stage 1: wave value and level; stage 2: product; stage 3: accumulate.
   logic               s1_vld_ff, s2_vld_ff;
   logic signed [16:0] s1_x_ff;
   logic signed [15:0] s1_rom_ff;
   logic               s1_rom_sel_ff;
   logic [7:0]         s1_lvl_ff;
   logic signed [38:0] s2_prod_ff;
   logic signed [21:0] acc_ff;
   logic               rsp_vld_ff;
   logic signed [15:0] rsp_ff;

   logic [31:0] ph, nph;
   logic [32:0] sum33;
   logic signed [16:0] x;
   logic signed [16:0] tri_v;
   logic signed [21:0] term, acc_next;
   logic [SineBits-1:0] sidx;
   logic last_voice;

   assign ph    = phase_ff[idx_ff];
   assign sum33 = {1'b0, ph} + {1'b0, step_ff[idx_ff]};
   assign nph   = sum33[31:0];
   assign sidx  = ph[31 -: SineBits];
   assign last_voice = (idx_ff == VoiceBits'(VoiceCount - 1));

   always_comb begin
      if (!ph[31]) tri_v = $signed({1'b0, ph[30:15]}) - 17'sd32768;
      else tri_v = 17'sd32768 - $signed({1'b0, ph[30:15]});
      if (tri_v > 17'sd32767) tri_v = 17'sd32767;
      case (wave_ff[idx_ff])
         // The table value comes through its own registered read.
         WaveSine:     x = 17'sd0;
         WaveTriangle: x = tri_v;
         WaveSaw:      x = $signed({1'b0, ph[31:16]}) - 17'sd32768;
         WaveNoise:    x = lfsr_ff[idx_ff][0] ? 17'sd32767 : -17'sd32768;
         default:      x = ph[31] ? -17'sd32768 : 17'sd32767;
      endcase
   end

   // Arithmetic shift floors, matching the rounding toward minus infinity.
   assign term = 22'(s2_prod_ff >>> 23);
   assign acc_next = acc_ff + term;

   assign cmd_pop   = cmd_valid && state_ff == S_IDLE && !rsp_vld_ff;
   assign rsp.valid = rsp_vld_ff;
   assign rsp.sample = rsp_ff;

   always_ff @(posedge clock) begin
      s1_x_ff       <= x;
      s1_rom_ff     <= SineRom[sidx];
      s1_rom_sel_ff <= (wave_ff[idx_ff] == WaveSine);
      s1_lvl_ff     <= level_ff[idx_ff];
      s2_prod_ff    <= (s1_rom_sel_ff ? 17'(s1_rom_ff) : s1_x_ff) *
                       $signed({1'b0, s1_lvl_ff}) * $signed({1'b0, MixGain});
      if (reset) begin
         state_ff   <= S_INIT;
         idx_ff     <= '0;
         last_ff    <= 1'b0;
         active_ff  <= '0;
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         acc_ff     <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (rsp_vld_ff && rsp.ready) rsp_vld_ff <= 1'b0;
         s1_vld_ff <= (state_ff == S_RUN) && active_ff[idx_ff];
         s2_vld_ff <= s1_vld_ff;
         if (s2_vld_ff) acc_ff <= acc_next;
         unique case (state_ff)
            S_INIT: begin
               // Sweep the voice table once after reset.
               phase_ff[idx_ff] <= '0;
               step_ff[idx_ff]  <= '0;
               wave_ff[idx_ff]  <= '0;
               level_ff[idx_ff] <= '0;
               lfsr_ff[idx_ff]  <= LfsrSeed;
               idx_ff <= last_voice ? '0 : idx_ff + 1'b1;
               if (last_voice) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (cmd_pop) begin
                  if (cmd_data.mode == ModeTick) begin
                     idx_ff   <= '0;
                     acc_ff   <= '0;
                     state_ff <= S_RUN;
                  end else begin
                     for (int k = 0; k < VoiceCount; k++) begin
                        if (cmd_data.voice_select == AllVoices ||
                            cmd_data.voice_select == 5'(k)) begin
                           if (cmd_data.phase_step == 32'd0) begin
                              active_ff[k] <= 1'b0;
                           end else begin
                              if (!active_ff[k]) phase_ff[k] <= '0;
                              step_ff[k]   <= cmd_data.phase_step;
                              wave_ff[k]   <= cmd_data.waveform;
                              level_ff[k]  <= cmd_data.level;
                              active_ff[k] <= 1'b1;
                           end
                        end
                     end
                  end
               end
            end
            S_RUN: begin
               if (active_ff[idx_ff]) begin
                  phase_ff[idx_ff] <= nph;
                  if (sum33[32])
                     lfsr_ff[idx_ff] <= (lfsr_ff[idx_ff] >> 1) ^
                                        (lfsr_ff[idx_ff][0] ? LfsrTaps : 16'd0);
               end
               idx_ff <= last_voice ? '0 : idx_ff + 1'b1;
               if (last_voice) begin
                  last_ff  <= 1'b0;
                  state_ff <= S_DRAIN;
               end
            end
            S_DRAIN: begin
               // Wait for the multiply stages to empty into the sum.
               last_ff <= 1'b1;
               if (last_ff && !s1_vld_ff && !s2_vld_ff) begin
                  if (acc_ff > 22'(SampleLimit)) rsp_ff <= 16'(SampleLimit);
                  else if (acc_ff < -22'(SampleLimit)) rsp_ff <= -16'(SampleLimit);
                  else rsp_ff <= acc_ff[15:0];
                  rsp_vld_ff <= 1'b1;
                  state_ff   <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

FILE: hdl/multi_voice_tone_mixer_core.sv
// Top level of the sixteen-voice tone mixer.
//  channel | direction | payload
//  req     | in        | mode, voice_select, phase_step, waveform, volume
//  rsp     | out       | sample
// A set item leaves the queue once the back end is idle with no sample waiting, and
// is applied as it leaves. A tick item leaves the queue the same way; the sequencer
// then visits each voice in turn and the sum drains before a valid sample appears.
// After reset the voice table is swept once before items run.
// Reset is synchronous. While a sample waits, the back end takes no command; the
// two-entry queue holds up to two transfers before req.ready drops.
module multi_voice_tone_mixer_core (
   input logic      clock,
   input logic      reset,
   mvtm_req_if.sink req,
   mvtm_rsp_if.source rsp
);
   import mvtm_pkg::*;

   cmd_type cmd_data;
   logic    cmd_valid, cmd_pop;

   mvtm_front u_front (.clock, .reset, .req, .cmd_data, .cmd_valid, .cmd_pop);
   mvtm_back  u_back  (.clock, .reset, .cmd_data, .cmd_valid, .cmd_pop, .rsp);
endmodule

FILE: hdl/mvtm_checker.sv
// Port-level checks for the tone mixer, bound to the top level.
module mvtm_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic signed [15:0] rsp_sample
);
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_sample <= 16'sd30000 && rsp_sample >= -16'sd30000))
      else $error("sample out of range");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample))
      else $error("response dropped while stalled");
   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response after reset");
   a_ready_after_reset: assert property (@(posedge clock) reset |=> req_ready)
      else $error("request side not ready after reset");
   a_ready_known: assert property (@(posedge clock) disable iff (reset)
      req_valid |-> !$isunknown(req_ready))
      else $error("request ready unknown while offered");
endmodule

bind multi_voice_tone_mixer_core mvtm_checker u_chk (
   .clock, .reset, .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_sample(rsp.sample));
